>>> sv/ddp_pkg.sv
// ----------------------------------------------------------------------------
// ddp_pkg
// Shared types and constants of the DDP datagram receiver.
// ----------------------------------------------------------------------------
package ddp_pkg;

   localparam int FRAME_SIZE_DEFAULT = 4096;
   localparam int ADDR_W             = 12;

   // header layout: byte positions within the datagram
   localparam logic [15:0] HDR_BYTES   = 16'd10;
   localparam logic [15:0] HDR_LAST    = 16'd9;
   localparam logic [3:0]  POS_FLAGS   = 4'd0;
   localparam logic [3:0]  POS_SEQ     = 4'd1;
   localparam logic [3:0]  POS_DEST    = 4'd3;
   localparam logic [3:0]  POS_OFS0    = 4'd4;
   localparam logic [3:0]  POS_OFS1    = 4'd5;
   localparam logic [3:0]  POS_OFS2    = 4'd6;
   localparam logic [3:0]  POS_OFS3    = 4'd7;
   localparam logic [3:0]  POS_LEN_HI  = 4'd8;
   localparam logic [3:0]  POS_LEN_LO  = 4'd9;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   localparam logic [7:0] VER_MASK     = 8'hC0;
   localparam logic [7:0] VER_ONE      = 8'h40;
   localparam logic [7:0] TIMECODE_BIT = 8'h10;
   localparam logic [7:0] PUSH_BIT     = 8'h01;
   localparam logic [7:0] SEQ_MASK     = 8'h0F;
   localparam logic [3:0] SEQ_TOP      = 4'd15;
   localparam logic [7:0] ID_DEFAULT   = 8'd1;
   localparam logic [7:0] ID_BROADCAST = 8'd255;
   localparam logic [7:0] DEVICE_ID_RESET = 8'd1;

   typedef enum logic [2:0] {
      V_DATA      = 3'd0,
      V_PUSH      = 3'd1,
      V_EMPTY     = 3'd2,
      V_MALFORMED = 3'd3,
      V_NOT_OURS  = 3'd4,
      V_OFFSET    = 3'd5
   } verdict_type;

   typedef struct packed {
      logic [7:0]  byte_value;
      logic        first_byte;
      logic        last_byte;
      logic [15:0] payload_length;
   } req_type;

   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] write_address;
      logic [7:0]        write_data;
      logic              latch;
      logic              packet_done;
      logic [2:0]        verdict;
      logic              sequence_gap;
   } rsp_type;

   // header check outcome, handed from the judge to the core
   typedef struct packed {
      verdict_type verdict;
      logic        accepting;
      logic        gap;
      logic        seq_write;
   } judge_type;

endpackage

>>> sv/ddp_hdr_judge.sv
// ----------------------------------------------------------------------------
// ddp_hdr_judge
// Checks a complete header and decides verdict, data acceptance and gap.
// ----------------------------------------------------------------------------
module ddp_hdr_judge #(
   parameter int FRAME_SIZE = ddp_pkg::FRAME_SIZE_DEFAULT
) (
   input  logic [7:0]         flag_byte,
   input  logic [3:0]         sequence_number,
   input  logic [7:0]         destination,
   input  logic [31:0]        data_offset,
   input  logic [15:0]        data_length,
   input  logic [15:0]        payload_length,
   input  logic [3:0]         last_sequence,
   input  logic [7:0]         device_id,
   output ddp_pkg::judge_type judge
);

   localparam logic [32:0] FRAME_LIM = 33'(FRAME_SIZE);

   logic       fits;
   logic       for_us;
   logic       too_short;
   logic [3:0] expect_seq;

   assign fits      = {1'b0, payload_length} >=
                      (17'(ddp_pkg::HDR_BYTES) + {1'b0, data_length});
   assign for_us    = (destination == device_id) || (destination == ddp_pkg::ID_DEFAULT) ||
                      (destination == ddp_pkg::ID_BROADCAST);
   assign too_short = payload_length < ddp_pkg::HDR_BYTES;
   // successor in 1..15, wrapping
   assign expect_seq = (last_sequence == ddp_pkg::SEQ_TOP) ? 4'd1 : last_sequence + 4'd1;

   always_comb begin
      judge.verdict   = ddp_pkg::V_DATA;
      judge.accepting = 1'b0;
      judge.gap       = 1'b0;
      judge.seq_write = 1'b0;
      if (too_short || ((flag_byte & ddp_pkg::VER_MASK) != ddp_pkg::VER_ONE) ||
          ((flag_byte & ddp_pkg::TIMECODE_BIT) != 8'd0)) begin
         judge.verdict = ddp_pkg::V_MALFORMED;
      end else if ((flag_byte & ddp_pkg::PUSH_BIT) != 8'd0) begin
         judge.verdict   = ddp_pkg::V_PUSH;
         judge.accepting = (data_length != 16'd0) && fits && for_us;
      end else if (data_length == 16'd0) begin
         judge.verdict = ddp_pkg::V_EMPTY;
      end else if (!for_us) begin
         judge.verdict = ddp_pkg::V_NOT_OURS;
      end else if (!fits) begin
         judge.verdict = ddp_pkg::V_MALFORMED;
      end else if ({1'b0, data_offset} >= FRAME_LIM) begin
         judge.verdict = ddp_pkg::V_OFFSET;
      end else begin
         judge.verdict   = ddp_pkg::V_DATA;
         judge.accepting = 1'b1;
         if (sequence_number != 4'd0) begin
            judge.seq_write = 1'b1;
            judge.gap = (last_sequence != 4'd0) && (sequence_number != expect_seq) &&
                        (sequence_number != last_sequence);
         end
      end
   end

endmodule

>>> sv/ddp_rx_core.sv
// ----------------------------------------------------------------------------
// ddp_rx_core
// Datagram state and per-byte result: header capture, writes, verdict.
// ----------------------------------------------------------------------------
module ddp_rx_core #(
   parameter int FRAME_SIZE = ddp_pkg::FRAME_SIZE_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  ddp_pkg::req_type req,
   input  logic [7:0]       device_id,
   output ddp_pkg::rsp_type rsp
);

   localparam logic [32:0] FRAME_LIM = 33'(FRAME_SIZE);

   logic [15:0]          byte_count_ff, byte_count_in;
   logic [7:0]           flag_byte_ff, flag_byte_in;
   logic [3:0]           seq_ff, seq_in;
   logic [7:0]           dest_ff, dest_in;
   logic [31:0]          offset_ff, offset_in;
   logic [15:0]          dlen_ff, dlen_in;
   logic                 accepting_ff, accepting_in;
   ddp_pkg::verdict_type pend_verdict_ff, pend_verdict_in;
   logic                 pend_gap_ff, pend_gap_in;
   logic [3:0]           last_seq_ff, last_seq_in;

   logic [15:0]          pos;
   logic                 acc;
   logic                 in_hdr;
   logic [15:0]          dlen_new;
   logic [15:0]          idx;
   logic [32:0]          target;
   ddp_pkg::judge_type   judge;
   ddp_pkg::verdict_type verd;
   logic                 gap_now;

   assign pos      = req.first_byte ? 16'd0 : byte_count_ff;
   assign acc      = req.first_byte ? 1'b0 : accepting_ff;
   assign in_hdr   = pos < ddp_pkg::HDR_BYTES;
   assign dlen_new = {dlen_ff[15:8], req.byte_value};
   assign idx      = pos - ddp_pkg::HDR_BYTES;
   assign target   = {1'b0, offset_ff} + {17'd0, idx};

   ddp_hdr_judge #(
      .FRAME_SIZE (FRAME_SIZE)
   ) u_judge (
      .flag_byte       (flag_byte_ff),
      .sequence_number (seq_ff),
      .destination     (dest_ff),
      .data_offset     (offset_ff),
      .data_length     (dlen_new),
      .payload_length  (req.payload_length),
      .last_sequence   (last_seq_ff),
      .device_id       (device_id),
      .judge           (judge)
   );

   // verdict of the header just completed on this byte, the stored one, or malformed before the header is complete
   always_comb begin
      if (pos < ddp_pkg::HDR_LAST) begin
         verd    = ddp_pkg::V_MALFORMED;
         gap_now = 1'b0;
      end else if (pos == ddp_pkg::HDR_LAST) begin
         verd    = judge.verdict;
         gap_now = judge.gap;
      end else begin
         verd    = pend_verdict_ff;
         gap_now = pend_gap_ff;
      end
   end

   always_comb begin
      byte_count_in   = byte_count_ff;
      flag_byte_in    = flag_byte_ff;
      seq_in          = seq_ff;
      dest_in         = dest_ff;
      offset_in       = offset_ff;
      dlen_in         = dlen_ff;
      accepting_in    = acc;
      pend_verdict_in = pend_verdict_ff;
      pend_gap_in     = pend_gap_ff;
      last_seq_in     = last_seq_ff;

      if (in_hdr) begin
         case (pos[3:0])
            ddp_pkg::POS_FLAGS: flag_byte_in = req.byte_value;
            ddp_pkg::POS_SEQ:   seq_in = 4'(req.byte_value & ddp_pkg::SEQ_MASK);
            ddp_pkg::POS_DEST:  dest_in = req.byte_value;
            ddp_pkg::POS_OFS0, ddp_pkg::POS_OFS1, ddp_pkg::POS_OFS2,
            ddp_pkg::POS_OFS3:  offset_in = {offset_ff[23:0], req.byte_value};
            ddp_pkg::POS_LEN_HI: dlen_in = {req.byte_value, 8'd0};
            ddp_pkg::POS_LEN_LO: begin
               dlen_in         = dlen_new;
               accepting_in    = judge.accepting;
               pend_verdict_in = judge.verdict;
               pend_gap_in     = judge.gap;
               if (judge.seq_write) begin
                  last_seq_in = seq_ff;
               end
            end
            default: ;
         endcase
      end

      if (req.last_byte) begin
         byte_count_in = 16'd0;
         accepting_in  = 1'b0;
      end else if (pos != ddp_pkg::COUNT_MAX) begin
         byte_count_in = pos + 16'd1;
      end else begin
         byte_count_in = pos;
      end
   end

   always_comb begin
      rsp = '0;
      if (!in_hdr && acc && (idx < dlen_ff) && (target < FRAME_LIM)) begin
         rsp.write_enable  = 1'b1;
         rsp.write_address = target[ddp_pkg::ADDR_W-1:0];
         rsp.write_data    = req.byte_value;
      end
      if (req.last_byte) begin
         rsp.packet_done  = 1'b1;
         rsp.verdict      = verd;
         rsp.sequence_gap = (verd == ddp_pkg::V_DATA) && gap_now;
         rsp.latch        = (verd == ddp_pkg::V_PUSH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         flag_byte_ff    <= '0;
         seq_ff          <= '0;
         dest_ff         <= '0;
         offset_ff       <= '0;
         dlen_ff         <= '0;
         accepting_ff    <= 1'b0;
         pend_verdict_ff <= ddp_pkg::V_DATA;
         pend_gap_ff     <= 1'b0;
         last_seq_ff     <= '0;
      end else if (advance) begin
         byte_count_ff   <= byte_count_in;
         flag_byte_ff    <= flag_byte_in;
         seq_ff          <= seq_in;
         dest_ff         <= dest_in;
         offset_ff       <= offset_in;
         dlen_ff         <= dlen_in;
         accepting_ff    <= accepting_in;
         pend_verdict_ff <= pend_verdict_in;
         pend_gap_ff     <= pend_gap_in;
         last_seq_ff     <= last_seq_in;
      end
   end

endmodule

>>> sv/ddp_packet_receiver.sv
// ----------------------------------------------------------------------------
// ddp_packet_receiver
// DDP datagram receiver: one payload byte in, one frame-buffer result out.
// ----------------------------------------------------------------------------
// Takes one UDP payload byte per cycle and returns one result per byte: the
// byte passes an input register, then the header capture and write logic,
// then the result register. Throughput is one byte per cycle with no gaps,
// set by that single register-to-register pass; back pressure on rsp_ready
// stalls the input through req_ready. The tenth byte triggers the header
// check; data bytes become writes at offset plus index, and writes at or
// past FRAME_SIZE are dropped. The last byte of each datagram carries
// packet_done, the verdict, the sequence-gap flag and, for push packets,
// latch. device_id is written through the csr_ channel (always ready) and
// should only change while no transaction is in flight.
module ddp_packet_receiver #(
   parameter int FRAME_SIZE = ddp_pkg::FRAME_SIZE_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ddp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ddp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);

   logic             s1_valid_ff, s1_valid_in;
   ddp_pkg::req_type s1_data_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   ddp_pkg::rsp_type rsp_data_ff;
   ddp_pkg::rsp_type rsp_next;
   logic [7:0]       device_id_ff;
   logic             advance;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   ddp_rx_core #(
      .FRAME_SIZE (FRAME_SIZE)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req       (s1_data_ff),
      .device_id (device_id_ff),
      .rsp       (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         device_id_ff <= ddp_pkg::DEVICE_ID_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            device_id_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

endmodule
